>>> src/uhe_pkg.sv
// Shared types, constants and the entity name table for the UTF-8 to HTML entity encoder.
// Used by the front decoder, the command queue, the byte emitter and the top level.
`timescale 1ns / 1ps
`default_nettype none

package uhe_pkg;

	// Command queue depth and pointer width.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Configuration register indexes.
	localparam logic REG_ASCII  = 1'b0;
	localparam logic REG_LATIN1 = 1'b1;

	// Entity indexes: 0..95 are the Latin-1 names, then the four ASCII names.
	localparam logic [6:0] ENT_QUOT = 7'd96;
	localparam logic [6:0] ENT_AMP  = 7'd97;
	localparam logic [6:0] ENT_LT   = 7'd98;
	localparam logic [6:0] ENT_GT   = 7'd99;
	localparam logic [7:0] LATIN1_BASE = 8'd160;

	// Bytes that frame every entity.
	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_SEMI = 8'h3B;

	// One character command from the front decoder to the byte emitter.
	typedef struct packed {
		logic        is_ent;     // emit a named entity
		logic [6:0]  ent_idx;    // entity table index
		logic [31:0] utf_bytes;  // raw or UTF-8 bytes, first byte in the low lane
		logic [2:0]  utf_count;  // number of valid bytes, 1 to 4
	} cmd_t;

	// Entity name, right-aligned: the last letter sits in the low byte, unused
	// upper bytes are zero.
	function automatic logic [47:0] ent_name(input logic [6:0] idx);
		logic [47:0] n;
		unique case (idx)
			7'd0:  n = 48'("nbsp");
			7'd1:  n = 48'("iexcl");
			7'd2:  n = 48'("cent");
			7'd3:  n = 48'("pound");
			7'd4:  n = 48'("curren");
			7'd5:  n = 48'("yen");
			7'd6:  n = 48'("brvbar");
			7'd7:  n = 48'("sect");
			7'd8:  n = 48'("uml");
			7'd9:  n = 48'("copy");
			7'd10: n = 48'("ordf");
			7'd11: n = 48'("laquo");
			7'd12: n = 48'("not");
			7'd13: n = 48'("shy");
			7'd14: n = 48'("reg");
			7'd15: n = 48'("macr");
			7'd16: n = 48'("deg");
			7'd17: n = 48'("plusmn");
			7'd18: n = 48'("sup2");
			7'd19: n = 48'("sup3");
			7'd20: n = 48'("acute");
			7'd21: n = 48'("micro");
			7'd22: n = 48'("para");
			7'd23: n = 48'("middot");
			7'd24: n = 48'("cedil");
			7'd25: n = 48'("sup1");
			7'd26: n = 48'("ordm");
			7'd27: n = 48'("raquo");
			7'd28: n = 48'("frac14");
			7'd29: n = 48'("frac12");
			7'd30: n = 48'("frac34");
			7'd31: n = 48'("iquest");
			7'd32: n = 48'("Agrave");
			7'd33: n = 48'("Aacute");
			7'd34: n = 48'("Acirc");
			7'd35: n = 48'("Atilde");
			7'd36: n = 48'("Auml");
			7'd37: n = 48'("Aring");
			7'd38: n = 48'("AElig");
			7'd39: n = 48'("Ccedil");
			7'd40: n = 48'("Egrave");
			7'd41: n = 48'("Eacute");
			7'd42: n = 48'("Ecirc");
			7'd43: n = 48'("Euml");
			7'd44: n = 48'("Igrave");
			7'd45: n = 48'("Iacute");
			7'd46: n = 48'("Icirc");
			7'd47: n = 48'("Iuml");
			7'd48: n = 48'("ETH");
			7'd49: n = 48'("Ntilde");
			7'd50: n = 48'("Ograve");
			7'd51: n = 48'("Oacute");
			7'd52: n = 48'("Ocirc");
			7'd53: n = 48'("Otilde");
			7'd54: n = 48'("Ouml");
			7'd55: n = 48'("times");
			7'd56: n = 48'("Oslash");
			7'd57: n = 48'("Ugrave");
			7'd58: n = 48'("Uacute");
			7'd59: n = 48'("Ucirc");
			7'd60: n = 48'("Uuml");
			7'd61: n = 48'("Yacute");
			7'd62: n = 48'("THORN");
			7'd63: n = 48'("szlig");
			7'd64: n = 48'("agrave");
			7'd65: n = 48'("aacute");
			7'd66: n = 48'("acirc");
			7'd67: n = 48'("atilde");
			7'd68: n = 48'("auml");
			7'd69: n = 48'("aring");
			7'd70: n = 48'("aelig");
			7'd71: n = 48'("ccedil");
			7'd72: n = 48'("egrave");
			7'd73: n = 48'("eacute");
			7'd74: n = 48'("ecirc");
			7'd75: n = 48'("euml");
			7'd76: n = 48'("igrave");
			7'd77: n = 48'("iacute");
			7'd78: n = 48'("icirc");
			7'd79: n = 48'("iuml");
			7'd80: n = 48'("eth");
			7'd81: n = 48'("ntilde");
			7'd82: n = 48'("ograve");
			7'd83: n = 48'("oacute");
			7'd84: n = 48'("ocirc");
			7'd85: n = 48'("otilde");
			7'd86: n = 48'("ouml");
			7'd87: n = 48'("divide");
			7'd88: n = 48'("oslash");
			7'd89: n = 48'("ugrave");
			7'd90: n = 48'("uacute");
			7'd91: n = 48'("ucirc");
			7'd92: n = 48'("uuml");
			7'd93: n = 48'("yacute");
			7'd94: n = 48'("thorn");
			7'd95: n = 48'("yuml");
			7'd96: n = 48'("quot");
			7'd97: n = 48'("amp");
			7'd98: n = 48'("lt");
			7'd99: n = 48'("gt");
			default: n = '0;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

>>> src/uhe_front.sv
// Front decoder: accepts UTF-8 bytes, rebuilds code points and classifies each
// finished character into a command. Depends on uhe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uhe_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    in_byte,
	input  wire logic          ascii_en,
	input  wire logic          latin1_en,
	output logic               push_valid,
	input  wire logic          push_ready,
	output uhe_pkg::cmd_t      push_cmd
);
	import uhe_pkg::*;

	logic [20:0] cp_q;
	logic [1:0]  rem_q;
	logic [20:0] cp_nxt;
	logic [1:0]  rem_nxt;
	logic [20:0] cp_ext;
	logic [20:0] cp_done;
	logic        char_go;
	logic        raw_go;
	logic        accept;

	// Classify a finished code point into an entity or its UTF-8 bytes.
	function automatic cmd_t char_cmd(input logic [20:0] cp, input logic a_en,
		input logic l_en);
		cmd_t c;
		c = '0;
		priority if (a_en && cp == 21'd34) begin
			c.is_ent  = 1'b1;
			c.ent_idx = ENT_QUOT;
		end else if (a_en && cp == 21'd38) begin
			c.is_ent  = 1'b1;
			c.ent_idx = ENT_AMP;
		end else if (a_en && cp == 21'd60) begin
			c.is_ent  = 1'b1;
			c.ent_idx = ENT_LT;
		end else if (a_en && cp == 21'd62) begin
			c.is_ent  = 1'b1;
			c.ent_idx = ENT_GT;
		end else if (l_en && cp[20:8] == '0 && cp[7:0] >= LATIN1_BASE) begin
			c.is_ent  = 1'b1;
			c.ent_idx = 7'(cp[7:0] - LATIN1_BASE);
		end else if (cp[20:7] == '0) begin
			c.utf_bytes[7:0] = {1'b0, cp[6:0]};
			c.utf_count      = 3'd1;
		end else if (cp[20:11] == '0) begin
			c.utf_bytes[7:0]  = {3'b110, cp[10:6]};
			c.utf_bytes[15:8] = {2'b10, cp[5:0]};
			c.utf_count       = 3'd2;
		end else if (cp[20:16] == '0) begin
			c.utf_bytes[7:0]   = {4'b1110, cp[15:12]};
			c.utf_bytes[15:8]  = {2'b10, cp[11:6]};
			c.utf_bytes[23:16] = {2'b10, cp[5:0]};
			c.utf_count        = 3'd3;
		end else begin
			c.utf_bytes[7:0]   = {5'b11110, cp[20:18]};
			c.utf_bytes[15:8]  = {2'b10, cp[17:12]};
			c.utf_bytes[23:16] = {2'b10, cp[11:6]};
			c.utf_bytes[31:24] = {2'b10, cp[5:0]};
			c.utf_count        = 3'd4;
		end
		return c;
	endfunction

	// Bytes are taken whenever the queue has room for a possible command.
	assign in_ready = push_ready;
	assign accept   = in_valid && in_ready;
	assign cp_ext   = {cp_q[14:0], in_byte[5:0]};

	// Decoder next state and the kind of request this byte produces.
	always_comb begin
		cp_nxt  = cp_q;
		rem_nxt = rem_q;
		cp_done = {13'd0, in_byte};
		char_go = 1'b0;
		raw_go  = 1'b0;
		priority if (in_byte == 8'd0) begin
			cp_nxt  = '0;
			rem_nxt = '0;
		end else if (rem_q != 2'd0) begin
			if (in_byte[7:6] == 2'b10) begin
				if (rem_q == 2'd1) begin
					cp_done = cp_ext;
					char_go = 1'b1;
					cp_nxt  = '0;
					rem_nxt = '0;
				end else begin
					cp_nxt  = cp_ext;
					rem_nxt = rem_q - 2'd1;
				end
			end else begin
				raw_go  = 1'b1;
				cp_nxt  = '0;
				rem_nxt = '0;
			end
		end else if (in_byte[7] == 1'b0) begin
			char_go = 1'b1;
		end else if (in_byte[7:6] == 2'b10) begin
			raw_go = 1'b1;
		end else if (in_byte[7:5] == 3'b110) begin
			cp_nxt  = {16'd0, in_byte[4:0]};
			rem_nxt = 2'd1;
		end else if (in_byte[7:4] == 4'b1110) begin
			cp_nxt  = {17'd0, in_byte[3:0]};
			rem_nxt = 2'd2;
		end else if (in_byte[7:3] == 5'b11110) begin
			cp_nxt  = {18'd0, in_byte[2:0]};
			rem_nxt = 2'd3;
		end else begin
			raw_go  = 1'b1;
			cp_nxt  = '0;
			rem_nxt = '0;
		end
	end

	// Build the command pushed into the queue.
	always_comb begin
		if (char_go) begin
			push_cmd = char_cmd(cp_done, ascii_en, latin1_en);
		end else begin
			push_cmd                = '0;
			push_cmd.utf_bytes[7:0] = in_byte;
			push_cmd.utf_count      = 3'd1;
		end
	end

	assign push_valid = in_valid && (char_go || raw_go);

	// Decoder state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_q  <= '0;
			rem_q <= '0;
		end else if (accept) begin
			cp_q  <= cp_nxt;
			rem_q <= rem_nxt;
		end
	end

endmodule

`default_nettype wire

>>> src/uhe_fifo.sv
// Short command queue between the front decoder and the byte emitter.
// Depends on uhe_pkg for the command type and depth.
`timescale 1ns / 1ps
`default_nettype none

module uhe_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_valid,
	output logic               wr_ready,
	input  wire uhe_pkg::cmd_t wr_cmd,
	output logic               rd_valid,
	input  wire logic          rd_ready,
	output uhe_pkg::cmd_t      rd_cmd
);
	import uhe_pkg::*;

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_wr;
	logic              do_rd;

	assign wr_ready = count_q != QCNT_W'(QDEPTH);
	assign rd_valid = count_q != '0;
	assign rd_cmd   = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> src/uhe_back.sv
// Byte emitter: expands one queued command into its entity or UTF-8 bytes, one
// byte per cycle unless stalled, via a registered output. Depends on uhe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uhe_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	output logic               cmd_ready,
	input  wire uhe_pkg::cmd_t cmd,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [7:0]         out_byte,
	output logic               out_last
);
	import uhe_pkg::*;

	cmd_t        cur_q;
	logic        cur_v_q;
	logic [2:0]  pos_q;
	logic        ov_q;
	logic [7:0]  ob_q;
	logic        ol_q;
	logic [47:0] name;
	logic [47:0] name_sh;
	logic [2:0]  name_len;
	logic [2:0]  sel;
	logic [7:0]  cur_byte;
	logic        cur_last;
	logic        adv;
	logic        emit;
	logic        take;

	// Entity name lookup and its length.
	always_comb begin
		name     = ent_name(cur_q.ent_idx);
		name_len = '0;
		for (int k = 0; k < 6; k++) begin
			name_len = name_len + 3'(name[k*8 +: 8] != 8'd0);
		end
		sel     = name_len - pos_q;
		name_sh = name >> {sel, 3'b000};
	end

	// Byte at the current position and whether it closes the run.
	always_comb begin
		if (cur_q.is_ent) begin
			cur_last = {1'b0, pos_q} == ({1'b0, name_len} + 4'd1);
			if (pos_q == 3'd0) begin
				cur_byte = CH_AMP;
			end else if (cur_last) begin
				cur_byte = CH_SEMI;
			end else begin
				cur_byte = name_sh[7:0];
			end
		end else begin
			cur_last = pos_q == (cur_q.utf_count - 3'd1);
			cur_byte = cur_q.utf_bytes[{pos_q[1:0], 3'b000} +: 8];
		end
	end

	assign adv       = !ov_q || out_ready;
	assign emit      = adv && cur_v_q;
	assign take      = !cur_v_q || (emit && cur_last);
	assign cmd_ready = take;

	// Current command and position within it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			pos_q   <= '0;
		end else if (take) begin
			cur_v_q <= cmd_valid;
			pos_q   <= '0;
		end else if (emit) begin
			pos_q <= pos_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cur_q <= cmd;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (adv) begin
			ov_q <= cur_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			ob_q <= cur_byte;
			ol_q <= cur_last;
		end
	end

	assign out_valid = ov_q;
	assign out_byte  = ob_q;
	assign out_last  = ol_q;

endmodule

`default_nettype wire

>>> src/utf8_to_html_entity_encoder_unit.sv
// UTF-8 to HTML entity encoder: one input byte per cycle while the queue has
// room; a finished character passes through the queue, the emitter's command
// register and the output register. Output runs one byte per cycle unless
// stalled; the 4-entry queue absorbs input while an up-to-8-byte entity drains.
// Reset clears the decoder, queue and output, and sets both enables to 1.
// Depends on uhe_pkg, uhe_front, uhe_fifo and uhe_back.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_html_entity_encoder_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  in_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_byte,
	output logic             out_last
);
	import uhe_pkg::*;

	logic ascii_en_q;
	logic latin1_en_q;
	logic cfg_wr;
	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ascii_en_q  <= 1'b1;
			latin1_en_q <= 1'b1;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_ASCII:  ascii_en_q  <= pwdata[0];
				REG_LATIN1: latin1_en_q <= pwdata[0];
				default:    ascii_en_q  <= ascii_en_q;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_ASCII:  prdata[0] = ascii_en_q;
			REG_LATIN1: prdata[0] = latin1_en_q;
			default:    prdata    = '0;
		endcase
	end

	// Decode front end.
	uhe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.ascii_en   (ascii_en_q),
		.latin1_en  (latin1_en_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	// Command queue.
	uhe_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.wr_cmd   (push_cmd),
		.rd_valid (pop_valid),
		.rd_ready (pop_ready),
		.rd_cmd   (pop_cmd)
	);

	// Byte emitter.
	uhe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (pop_valid),
		.cmd_ready (pop_ready),
		.cmd       (pop_cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

endmodule

`default_nettype wire
